### src/ufbs_pkg.sv
// Shared types and constants for the fractional baud divider search.
// Used by ufbs_divider and uart_fractional_baud_search; no dependencies.
package ufbs_pkg;

  localparam int unsigned ClkW   = 27;
  localparam int unsigned BaudW  = 22;
  localparam int unsigned ErrW   = 27;
  localparam int unsigned CandW  = 28;
  localparam int unsigned DivW   = 31;
  localparam int unsigned CntW   = 5;

  localparam logic [ClkW-1:0]  ClkReset   = 27'd12000000;
  localparam logic [CandW-1:0] LatchLimit = 28'h000FFFF;

  localparam logic CfgIdxClk  = 1'b0;
  localparam logic CfgIdxFrac = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PAIR   = 10'b00_0000_0010,
    ST_GO1    = 10'b00_0000_0100,
    ST_WAIT1  = 10'b00_0000_1000,
    ST_CAND   = 10'b00_0001_0000,
    ST_GO2    = 10'b00_0010_0000,
    ST_WAIT2  = 10'b00_0100_0000,
    ST_UPD    = 10'b00_1000_0000,
    ST_NEXT   = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### src/ufbs_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ufbs_pkg for widths and the request and response structs.
module ufbs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ufbs_pkg::div_req_t req_i,
  output ufbs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = ufbs_pkg::DivW;

  logic                       busy_q;
  logic                       done_q;
  logic [ufbs_pkg::CntW-1:0]  cnt_q;
  logic [W-1:0]               rem_q;
  logic [W-1:0]               quo_q;
  logic [W-1:0]               dvs_q;
  logic [W:0]                 shifted;
  logic [W:0]                 diff;
  logic                       qbit;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign qbit    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ufbs_pkg::CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - ufbs_pkg::CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && !done_q)
    else $error("divider did not begin after start");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

### src/uart_fractional_baud_search.sv
// Top level of the fractional baud divider search: sequencer and configuration.
// Depends on ufbs_pkg and ufbs_divider.
//
//   channel | signals                                   | direction
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | in, write only
//   in      | in_valid_i, in_ready_o, baud_rate_i       | in
//   out     | out_valid_o, out_ready_i, multiplier_o,   | out
//           | divide_add_o, divisor_latch_o,            |
//           | baud_error_o, no_fit_o                    |
//
// Each division, issue included, runs in the one shared restoring divider.
// A prescaler pair needs at most three divisions plus steps.
// With fractional mode on, a full search covers 240 pairs, else only one; it ends early
// once an error of at most one is found. A zero request goes straight to the finish step.
// One item is searched at a time; a finished result waits in the output
// register while the next item is accepted, and a search holds in its last step while that
// register is full. Reset restores the clock and fractional enable registers.
module uart_fractional_baud_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [26:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [21:0] baud_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  multiplier_o,
  output logic [3:0]  divide_add_o,
  output logic [15:0] divisor_latch_o,
  output logic [22:0] baud_error_o,
  output logic        no_fit_o
);

  ufbs_pkg::state_e   state_q, state_d;
  ufbs_pkg::div_req_t div_req;
  ufbs_pkg::div_rsp_t div_rsp;

  logic [ufbs_pkg::ClkW-1:0]  clk_hz_q;
  logic                       frac_en_q;
  logic [ufbs_pkg::BaudW-1:0] baud_q;
  logic [3:0]                 mul_q;
  logic [3:0]                 add_q;
  logic [4:0]                 sum_q;
  logic [ufbs_pkg::DivW-1:0]  num_q;
  logic [ufbs_pkg::DivW-1:0]  den_q;
  logic [ufbs_pkg::DivW-1:0]  dvs_q;
  logic [ufbs_pkg::CandW-1:0] cand_q;
  logic                       k_q;
  logic [ufbs_pkg::ErrW-1:0]  err_q;
  logic [ufbs_pkg::ErrW-1:0]  best_err_q;
  logic [3:0]                 best_mul_q;
  logic [3:0]                 best_add_q;
  logic [15:0]                best_div_q;
  logic                       found_q;
  logic                       out_valid_q;
  logic                       in_acc;
  logic                       stop;
  logic                       cand_skip;
  logic                       better;
  logic                       last_add;
  logic                       last_mul;
  logic                       out_free;
  logic [4:0]                 pair_sum;
  logic [ufbs_pkg::ErrW-1:0]  achieved;
  logic [ufbs_pkg::ErrW-1:0]  baud_ext;

  assign in_ready_o = (state_q == ufbs_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign stop       = found_q && (best_err_q <= ufbs_pkg::ErrW'(1));
  assign cand_skip  = (cand_q == '0) || (cand_q >= ufbs_pkg::LatchLimit);
  assign better     = !found_q || (err_q < best_err_q);
  assign last_add   = frac_en_q ? (add_q == 4'd15) : (add_q == 4'd0);
  assign last_mul   = frac_en_q ? (mul_q == 4'd15) : (mul_q == 4'd1);
  assign out_free   = !out_valid_q || out_ready_i;
  assign pair_sum   = {1'b0, mul_q} + {1'b0, add_q};
  assign achieved   = div_rsp.quotient[ufbs_pkg::ErrW-1:0];
  assign baud_ext   = ufbs_pkg::ErrW'(baud_q);

  assign div_req.start    = (state_q == ufbs_pkg::ST_GO1) || (state_q == ufbs_pkg::ST_GO2);
  assign div_req.dividend = num_q;
  assign div_req.divisor  = (state_q == ufbs_pkg::ST_GO1) ? den_q : dvs_q;

  ufbs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ufbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (baud_rate_i == '0) ? ufbs_pkg::ST_FINISH : ufbs_pkg::ST_PAIR;
        end
      end
      ufbs_pkg::ST_PAIR:  state_d = stop ? ufbs_pkg::ST_FINISH : ufbs_pkg::ST_GO1;
      ufbs_pkg::ST_GO1:   state_d = ufbs_pkg::ST_WAIT1;
      ufbs_pkg::ST_WAIT1: begin
        if (div_rsp.done) begin
          state_d = ufbs_pkg::ST_CAND;
        end
      end
      ufbs_pkg::ST_CAND:  state_d = cand_skip ? ufbs_pkg::ST_NEXT : ufbs_pkg::ST_GO2;
      ufbs_pkg::ST_GO2:   state_d = ufbs_pkg::ST_WAIT2;
      ufbs_pkg::ST_WAIT2: begin
        if (div_rsp.done) begin
          state_d = ufbs_pkg::ST_UPD;
        end
      end
      ufbs_pkg::ST_UPD:   state_d = ufbs_pkg::ST_NEXT;
      ufbs_pkg::ST_NEXT: begin
        if (!k_q) begin
          state_d = ufbs_pkg::ST_CAND;
        end else if (last_add && last_mul) begin
          state_d = ufbs_pkg::ST_FINISH;
        end else begin
          state_d = ufbs_pkg::ST_PAIR;
        end
      end
      ufbs_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = ufbs_pkg::ST_IDLE;
        end
      end
      default: state_d = ufbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufbs_pkg::ST_IDLE;
      clk_hz_q    <= ufbs_pkg::ClkReset;
      frac_en_q   <= 1'b1;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ufbs_pkg::CfgIdxClk:  clk_hz_q  <= cfg_data_i;
          ufbs_pkg::CfgIdxFrac: frac_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        found_q <= 1'b0;
      end else if (state_q == ufbs_pkg::ST_UPD && better) begin
        found_q <= 1'b1;
      end
      if (state_q == ufbs_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ufbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          baud_q <= baud_rate_i;
          mul_q  <= 4'd1;
          add_q  <= 4'd0;
        end
      end
      ufbs_pkg::ST_PAIR: begin
        num_q <= {4'b0000, clk_hz_q} * {27'd0, mul_q};
        sum_q <= pair_sum;
        den_q <= {({5'd0, baud_q} * {22'd0, pair_sum}), 4'b0000};
      end
      ufbs_pkg::ST_WAIT1: begin
        cand_q <= div_rsp.quotient[ufbs_pkg::CandW-1:0];
        k_q    <= 1'b0;
      end
      ufbs_pkg::ST_CAND: begin
        dvs_q <= {6'd0, ({5'd0, cand_q[15:0]} * {16'd0, sum_q}), 4'b0000};
      end
      ufbs_pkg::ST_WAIT2: begin
        err_q <= (achieved > baud_ext) ? (achieved - baud_ext) : (baud_ext - achieved);
      end
      ufbs_pkg::ST_UPD: begin
        if (better) begin
          best_err_q <= err_q;
          best_mul_q <= mul_q;
          best_add_q <= add_q;
          best_div_q <= cand_q[15:0];
        end
      end
      ufbs_pkg::ST_NEXT: begin
        if (!k_q) begin
          k_q    <= 1'b1;
          cand_q <= cand_q + ufbs_pkg::CandW'(1);
        end else if (last_add) begin
          add_q <= 4'd0;
          mul_q <= mul_q + 4'd1;
        end else begin
          add_q <= add_q + 4'd1;
        end
      end
      ufbs_pkg::ST_FINISH: begin
        if (out_free) begin
          multiplier_o    <= found_q ? best_mul_q : 4'd1;
          divide_add_o    <= found_q ? best_add_q : 4'd0;
          divisor_latch_o <= found_q ? best_div_q : 16'd1;
          baud_error_o    <= found_q ? best_err_q[22:0] : 23'd0;
          no_fit_o        <= !found_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_nonzero_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && baud_rate_i != '0) |=> state_q == ufbs_pkg::ST_PAIR)
    else $error("search did not start after a nonzero request");
  a_no_fit_default : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_fit_o) |->
      (multiplier_o == 4'd1 && divide_add_o == 4'd0 &&
       divisor_latch_o == 16'd1 && baud_error_o == 23'd0))
    else $error("no-fit result is not the default setting");
  a_fit_latch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !no_fit_o) |->
      (divisor_latch_o != 16'd0 && divisor_latch_o != 16'hFFFF && multiplier_o != 4'd0))
    else $error("chosen setting out of range");
  a_update_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ufbs_pkg::ST_UPD) |=> found_q)
    else $error("candidate update did not mark a fit");

endmodule
